@@ rtl/core/cbkh_pkg.sv @@
// Package for the canonical binary k-mer hasher: base codes, ASCII values,
// coder selects, config register indexes and reset values, decode functions.
// No dependencies.
package cbkh_pkg;

  localparam int SEL_W     = 64;
  localparam int IDX_W     = 32;
  localparam int CFG_IDX_W = 2;

  typedef logic [2:0] base_code_t;
  typedef logic [1:0] coder_sel_t;

  localparam base_code_t CODE_A   = 3'd0;
  localparam base_code_t CODE_C   = 3'd1;
  localparam base_code_t CODE_G   = 3'd2;
  localparam base_code_t CODE_T   = 3'd3;
  localparam base_code_t CODE_BAD = 3'd4;

  localparam logic [7:0] ASCII_A_UC = 8'd65;
  localparam logic [7:0] ASCII_A_LC = 8'd97;
  localparam logic [7:0] ASCII_C_UC = 8'd67;
  localparam logic [7:0] ASCII_C_LC = 8'd99;
  localparam logic [7:0] ASCII_G_UC = 8'd71;
  localparam logic [7:0] ASCII_G_LC = 8'd103;
  localparam logic [7:0] ASCII_T_UC = 8'd84;
  localparam logic [7:0] ASCII_T_LC = 8'd116;

  localparam coder_sel_t CODER_AT = 2'd0;
  localparam coder_sel_t CODER_AC = 2'd1;
  localparam coder_sel_t CODER_AG = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SET0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SET2 = 2'd2;

  localparam logic [SEL_W-1:0] SEL0_RST = 64'h0000_0000_0000_0000;
  localparam logic [SEL_W-1:0] SEL1_RST = 64'h5555_5555_5555_5555;
  localparam logic [SEL_W-1:0] SEL2_RST = 64'hAAAA_AAAA_AAAA_AAAA;

  typedef struct packed {
    logic full;
    logic all_acgt;
  } win_stat_t;

  function automatic base_code_t char_to_code(input logic [7:0] ch);
    base_code_t code;
    case (ch)
      ASCII_A_UC, ASCII_A_LC: code = CODE_A;
      ASCII_C_UC, ASCII_C_LC: code = CODE_C;
      ASCII_G_UC, ASCII_G_LC: code = CODE_G;
      ASCII_T_UC, ASCII_T_LC: code = CODE_T;
      default:                code = CODE_BAD;
    endcase
    return code;
  endfunction

  function automatic logic code_bit(input coder_sel_t sel, input logic [1:0] b);
    logic bit_v;
    case (sel)
      CODER_AT: bit_v = (b == CODE_A[1:0]) || (b == CODE_T[1:0]);
      CODER_AC: bit_v = (b == CODE_A[1:0]) || (b == CODE_C[1:0]);
      default:  bit_v = (b == CODE_A[1:0]) || (b == CODE_G[1:0]);
    endcase
    return bit_v;
  endfunction

endpackage

@@ rtl/core/cbkh_window.sv @@
// Base window: decodes the incoming character, shifts it into the window
// and tracks the fill count. Depends on cbkh_pkg.
module cbkh_window import cbkh_pkg::*; #(
  parameter int KMER_LEN = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  logic [7:0]                  base_char,
  input  logic                        new_sequence,
  output logic [KMER_LEN-1:0][2:0]    window,
  output win_stat_t                   stat
);

  localparam int CW = $clog2(KMER_LEN + 1);

  logic [KMER_LEN-1:0][2:0] win_r, win_nxt;
  logic [CW-1:0]            fill_r, fill_nxt, fill_base;
  logic [KMER_LEN-1:0]      good;

  always_comb begin
    fill_base = new_sequence ? '0 : fill_r;
    fill_nxt  = (fill_base == CW'(KMER_LEN)) ? fill_base : fill_base + CW'(1);
    win_nxt   = {char_to_code(base_char), win_r[KMER_LEN-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (take) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      win_r <= win_nxt;
    end
  end

  genvar z;
  generate
    for (z = 0; z < KMER_LEN; z++) begin : g_good
      assign good[z] = (win_r[z] != CODE_BAD);
    end
  endgenerate

  assign window        = win_r;
  assign stat.full     = (fill_r == CW'(KMER_LEN));
  assign stat.all_acgt = &good;

endmodule

@@ rtl/core/cbkh_canon.sv @@
// Canonical index for one coder set: forward and reverse-complement binary
// codes of the window, smaller one wins. Depends on cbkh_pkg.
module cbkh_canon import cbkh_pkg::*; #(
  parameter int KMER_LEN = 32
) (
  input  logic [KMER_LEN-1:0][2:0] window,
  input  logic [SEL_W-1:0]         sel,
  output logic [KMER_LEN-1:0]      index
);

  logic [KMER_LEN-1:0] fwd, rc;

  genvar z;
  generate
    for (z = 0; z < KMER_LEN; z++) begin : g_pos
      assign fwd[KMER_LEN-1-z] = code_bit(sel[2*z +: 2], window[z][1:0]);
      assign rc[z] = code_bit(sel[2*(KMER_LEN-1-z) +: 2], ~window[z][1:0]);
    end
  endgenerate

  assign index = (fwd < rc) ? fwd : rc;

endmodule

@@ rtl/core/canonical_binary_kmer_hasher_top.sv @@
// Datapath: an input transaction is registered in the window register, then in
// the result register. Throughput: one transaction per cycle while out_ready holds.
// The result register acts as a skid stage, so input stays ready while a
// result waits as long as the window stage is free or moving on.
// Synchronous active-low reset clears the fill count, both stage valids and
// loads the coder select registers with their default patterns.
module canonical_binary_kmer_hasher_top import cbkh_pkg::*; #(
  parameter int KMER_LEN = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_base_char,
  input  logic                 in_new_sequence,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_window_full,
  output logic                 out_kmer_valid,
  output logic [IDX_W-1:0]     out_canonical_index_0,
  output logic [IDX_W-1:0]     out_canonical_index_1,
  output logic [IDX_W-1:0]     out_canonical_index_2,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SEL_W-1:0]     cfg_data
);

  logic [SEL_W-1:0]         sel0_r, sel1_r, sel2_r;
  logic                     s1_vld_r, s1_vld_nxt;
  logic                     out_vld_r, out_vld_nxt;
  logic                     s1_adv, take, kmer_ok;
  logic [KMER_LEN-1:0][2:0] window;
  win_stat_t                stat;
  logic [KMER_LEN-1:0]      idx0, idx1, idx2;
  logic                     full_r, kvalid_r;
  logic [IDX_W-1:0]         ci0_r, ci1_r, ci2_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel0_r <= SEL0_RST;
      sel1_r <= SEL1_RST;
      sel2_r <= SEL2_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SET0: sel0_r <= cfg_data;
        CFG_SET1: sel1_r <= cfg_data;
        CFG_SET2: sel2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_adv   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;
  assign take     = in_valid && in_ready;

  always_comb begin
    s1_vld_nxt  = take ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_r);
    out_vld_nxt = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  cbkh_window #(.KMER_LEN(KMER_LEN)) u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .base_char    (in_base_char),
    .new_sequence (in_new_sequence),
    .window       (window),
    .stat         (stat)
  );

  cbkh_canon #(.KMER_LEN(KMER_LEN)) u_canon0 (
    .window (window), .sel (sel0_r), .index (idx0)
  );
  cbkh_canon #(.KMER_LEN(KMER_LEN)) u_canon1 (
    .window (window), .sel (sel1_r), .index (idx1)
  );
  cbkh_canon #(.KMER_LEN(KMER_LEN)) u_canon2 (
    .window (window), .sel (sel2_r), .index (idx2)
  );

  assign kmer_ok = stat.full && stat.all_acgt;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      full_r   <= stat.full;
      kvalid_r <= kmer_ok;
      ci0_r    <= kmer_ok ? IDX_W'(idx0) : '0;
      ci1_r    <= kmer_ok ? IDX_W'(idx1) : '0;
      ci2_r    <= kmer_ok ? IDX_W'(idx2) : '0;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_window_full       = full_r;
  assign out_kmer_valid        = kvalid_r;
  assign out_canonical_index_0 = ci0_r;
  assign out_canonical_index_1 = ci1_r;
  assign out_canonical_index_2 = ci2_r;

endmodule

@@ rtl/core/cbkh_chk.sv @@
// Port-level checker for the canonical binary k-mer hasher, bound to the top
// level. Depends on cbkh_pkg.
module cbkh_chk import cbkh_pkg::*; #(
  parameter int KMER_LEN = 32
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_window_full,
  input logic                 out_kmer_valid,
  input logic [IDX_W-1:0]     out_canonical_index_0,
  input logic [IDX_W-1:0]     out_canonical_index_1,
  input logic [IDX_W-1:0]     out_canonical_index_2
);

  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'((64'd1 << KMER_LEN) - 64'd1);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_canonical_index_0)
      && $stable(out_canonical_index_1) && $stable(out_canonical_index_2)
      && $stable(out_kmer_valid) && $stable(out_window_full))
    else $error("result changed while stalled");

  a_valid_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kmer_valid |-> out_window_full)
    else $error("kmer valid without full window");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kmer_valid |-> out_canonical_index_0 == '0
      && out_canonical_index_1 == '0 && out_canonical_index_2 == '0)
    else $error("nonzero index on invalid kmer");

  a_index_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_canonical_index_0 & ~IDX_MASK) == '0
      && (out_canonical_index_1 & ~IDX_MASK) == '0
      && (out_canonical_index_2 & ~IDX_MASK) == '0)
    else $error("index bits above k-mer length");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind canonical_binary_kmer_hasher_top cbkh_chk #(.KMER_LEN(KMER_LEN)) u_cbkh_chk (.*);

@@ bench/kmer_hash_checker.sv @@
// Checker for the canonical binary k-mer hasher: tracks coder selects and the base window,
// predicts each result transaction and compares it field by field.
// Depends on cbkh_pkg for widths, base codes, ASCII values and register indexes.
module kmer_hash_checker import cbkh_pkg::*; #(
  parameter int KMER_LEN = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [7:0]           in_base_char,
  input  logic                 in_new_sequence,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 out_window_full,
  input  logic                 out_kmer_valid,
  input  logic [IDX_W-1:0]     out_canonical_index_0,
  input  logic [IDX_W-1:0]     out_canonical_index_1,
  input  logic [IDX_W-1:0]     out_canonical_index_2,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SEL_W-1:0]     cfg_data,
  output int                   n_pending,
  output int                   n_errors
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             full;
    logic             valid;
    logic [IDX_W-1:0] idx0;
    logic [IDX_W-1:0] idx1;
    logic [IDX_W-1:0] idx2;
  } kmer_result_t;

  kmer_result_t     pending_kmers[$];
  base_code_t       window_codes[KMER_LEN];
  int               fill_level;
  logic [SEL_W-1:0] sel_set[3];
  int               error_count = 0;

  assign n_errors = error_count;

  function automatic base_code_t decode_base(input logic [7:0] ch);
    logic [7:0] folded;
    folded = ch & 8'hDF;
    case (folded)
      ASCII_A_UC: return CODE_A;
      ASCII_C_UC: return CODE_C;
      ASCII_G_UC: return CODE_G;
      ASCII_T_UC: return CODE_T;
      default:    return CODE_BAD;
    endcase
  endfunction

  function automatic logic coder_bit(input coder_sel_t sel, input logic [1:0] b);
    case (sel)
      CODER_AT: return b[1] ~^ b[0];
      CODER_AC: return !b[1];
      default:  return !b[0];
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] canonical_index_of(input logic [SEL_W-1:0] sel);
    logic [IDX_W-1:0] fwd;
    logic [IDX_W-1:0] rc;
    logic [1:0]       b;
    int               mz;
    fwd = '0;
    rc  = '0;
    for (int z = 0; z < KMER_LEN; z++) begin
      b       = window_codes[z][1:0];
      mz      = KMER_LEN - 1 - z;
      fwd[mz] = coder_bit(sel[2*z +: 2], b);
      rc[z]   = coder_bit(sel[2*mz +: 2], ~b);
    end
    return (fwd < rc) ? fwd : rc;
  endfunction

  function automatic kmer_result_t hash_base(input logic [7:0] ch, input logic new_seq);
    kmer_result_t r;
    base_code_t   code;
    code = decode_base(ch);
    if (new_seq) fill_level = 0;
    if (fill_level >= KMER_LEN) begin
      for (int z = 0; z < KMER_LEN - 1; z++) window_codes[z] = window_codes[z+1];
      window_codes[KMER_LEN-1] = code;
    end else begin
      window_codes[fill_level] = code;
      fill_level++;
    end
    r       = '0;
    r.full  = (fill_level == KMER_LEN);
    r.valid = r.full;
    for (int z = 0; z < KMER_LEN; z++) begin
      if (window_codes[z] == CODE_BAD) r.valid = 1'b0;
    end
    if (r.valid) begin
      r.idx0 = canonical_index_of(sel_set[0]);
      r.idx1 = canonical_index_of(sel_set[1]);
      r.idx2 = canonical_index_of(sel_set[2]);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [IDX_W-1:0] got,
                                 input logic [IDX_W-1:0] want);
    if (error_count < 100)
      $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    kmer_result_t want;
    kmer_result_t fresh;
    if (!rst_n) begin
      fill_level = 0;
      for (int z = 0; z < KMER_LEN; z++) window_codes[z] = CODE_A;
      sel_set[0] = SEL0_RST;
      sel_set[1] = SEL1_RST;
      sel_set[2] = SEL2_RST;
      pending_kmers.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SET0: sel_set[0] = cfg_data;
          CFG_SET1: sel_set[1] = cfg_data;
          CFG_SET2: sel_set[2] = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_kmers.size() == 0) begin
          report_mismatch("unexpected result transaction", '0, '0);
        end else begin
          want = pending_kmers.pop_front();
          if (out_window_full !== want.full)
            report_mismatch("window_full", IDX_W'(out_window_full), IDX_W'(want.full));
          if (out_kmer_valid !== want.valid)
            report_mismatch("kmer_valid", IDX_W'(out_kmer_valid), IDX_W'(want.valid));
          if (out_canonical_index_0 !== want.idx0)
            report_mismatch("canonical_index_0", out_canonical_index_0, want.idx0);
          if (out_canonical_index_1 !== want.idx1)
            report_mismatch("canonical_index_1", out_canonical_index_1, want.idx1);
          if (out_canonical_index_2 !== want.idx2)
            report_mismatch("canonical_index_2", out_canonical_index_2, want.idx2);
        end
      end
      if (in_valid && in_ready) begin
        fresh = hash_base(in_base_char, in_new_sequence);
        pending_kmers.insert(pending_kmers.size(), fresh);
      end
    end
    n_pending <= pending_kmers.size();
  end

endmodule

@@ bench/testbench.sv @@
// Top of the k-mer hasher bench: clock, reset, base stream, coder select writes and verdict.
// Depends on cbkh_pkg, canonical_binary_kmer_hasher_top and kmer_hash_checker.
module testbench import cbkh_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 155;
  localparam int QUIET_LIMIT = 2000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_base_char = '0;
  logic                 in_new_sequence = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_window_full;
  logic                 out_kmer_valid;
  logic [IDX_W-1:0]     out_canonical_index_0;
  logic [IDX_W-1:0]     out_canonical_index_1;
  logic [IDX_W-1:0]     out_canonical_index_2;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SEL_W-1:0]     cfg_data = '0;

  int   n_pending;
  int   n_errors;
  int   bases_sent = 0;
  int   quiet_cycles = 0;
  logic calm = 1'b0;

  logic [7:0] nuc_chars[8] = '{ASCII_A_UC, ASCII_C_UC, ASCII_G_UC, ASCII_T_UC,
                               ASCII_A_LC, ASCII_C_LC, ASCII_G_LC, ASCII_T_LC};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  canonical_binary_kmer_hasher_top u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_base_char         (in_base_char),
    .in_new_sequence      (in_new_sequence),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_window_full      (out_window_full),
    .out_kmer_valid       (out_kmer_valid),
    .out_canonical_index_0(out_canonical_index_0),
    .out_canonical_index_1(out_canonical_index_1),
    .out_canonical_index_2(out_canonical_index_2),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  kmer_hash_checker u_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_base_char         (in_base_char),
    .in_new_sequence      (in_new_sequence),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_window_full      (out_window_full),
    .out_kmer_valid       (out_kmer_valid),
    .out_canonical_index_0(out_canonical_index_0),
    .out_canonical_index_1(out_canonical_index_1),
    .out_canonical_index_2(out_canonical_index_2),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .n_pending            (n_pending),
    .n_errors             (n_errors)
  );

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 30);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_base(input logic [7:0] ch, input logic new_seq);
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_base_char    <= ch;
    in_new_sequence <= new_seq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    bases_sent++;
  endtask

  task automatic wait_drained();
    while (n_pending != 0) @(negedge clk);
  endtask

  task automatic write_sel(input logic [CFG_IDX_W-1:0] idx, input logic [SEL_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_read(input int len, input int bad_pct, input logic hold_mid);
    logic [7:0] ch;
    for (int i = 0; i < len; i++) begin
      if (hold_mid && i == len / 2) begin
        in_valid <= 1'b0;
        wait_drained();
      end
      if ($urandom_range(99) < bad_pct) ch = 8'($urandom_range(255));
      else ch = nuc_chars[$urandom_range(7)];
      send_base(ch, (i == 0) || ($urandom_range(199) == 0));
    end
  endtask

  initial begin
    logic [SEL_W-1:0] s0, s1, s2;
    int               kind;
    logic             hold;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        in_valid <= 1'b0;
        wait_drained();
        case (p)
          1: begin s0 = '0; s1 = '1; s2 = SEL1_RST; end
          2: begin s0 = '1; s1 = '1; s2 = '1; end
          4: begin s0 = SEL2_RST; s1 = '0; s2 = '0; end
          default: begin
            s0 = {$urandom, $urandom};
            s1 = {$urandom, $urandom};
            s2 = {$urandom, $urandom};
          end
        endcase
        write_sel(CFG_SET0, s0);
        write_sel(CFG_SET1, s1);
        write_sel(CFG_SET2, s2);
        if (p == 1) write_sel(CFG_SPARE, {$urandom, $urandom});
        cfg_valid <= 1'b0;
      end
      calm = (p == 2);

      if (p == 0) begin
        send_base(ASCII_A_UC, 1'b1);
        send_base(ASCII_C_UC, 1'b0);
        send_base(ASCII_G_UC, 1'b0);
        send_base(ASCII_T_UC, 1'b0);
        send_base(ASCII_A_LC, 1'b0);
        send_base(ASCII_C_LC, 1'b0);
        send_base(ASCII_G_LC, 1'b0);
        send_base(ASCII_T_LC, 1'b0);
        send_base(8'h00, 1'b0);
        send_base(8'hFF, 1'b0);
        send_base(8'hC1, 1'b0);
        send_base(8'hE7, 1'b0);
        send_base(8'h4E, 1'b0);
        send_base(8'hFF, 1'b1);
        send_base(8'h00, 1'b0);
        send_base(ASCII_T_LC, 1'b1);
        send_base(8'h21, 1'b0);
        send_base(8'h5A, 1'b0);
        send_base(ASCII_G_UC, 1'b1);
        send_base(ASCII_A_LC, 1'b1);
      end

      hold = (p == 3);
      while (bases_sent < (p + 1) * PHASE_ITEMS + 20) begin
        kind = $urandom_range(99);
        if (kind < 70)      send_read($urandom_range(33, 90), 0, hold);
        else if (kind < 85) send_read($urandom_range(33, 70), 3, hold);
        else if (kind < 95) send_read($urandom_range(1, 31), 5, hold);
        else                send_read($urandom_range(5, 40), 100, hold);
        hold = 1'b0;
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
